### hw/rtl/ihb_pkg.sv
// Shared constants, types and helper functions for the triangular-lattice
// heat-bath site update block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ihb_pkg;

  // Lattice geometry.
  localparam int LATTICE_WIDTH  = 4;
  localparam int LATTICE_HEIGHT = 8;
  localparam int SITE_COUNT     = LATTICE_WIDTH * LATTICE_HEIGHT;
  localparam int SITE_W         = $clog2(SITE_COUNT);

  // Field widths of the command and result words.
  localparam int OP_W   = 2;
  localparam int COL_W  = 2;
  localparam int ROW_W  = 3;
  localparam int DRAW_W = 31;
  localparam int THR_W  = 32;
  localparam int MAG_W  = 7;
  localparam int CNT_W  = 6;

  // Threshold table: one entry per possible count of up neighbors (0..6).
  localparam int THR_COUNT = 7;
  localparam int CFG_IDX_W = 3;
  localparam int NBR_W     = 3;

  // The up counter saturates at the site count, or at its own maximum.
  localparam int CNT_MAX     = (1 << CNT_W) - 1;
  localparam int COUNT_LIMIT = (SITE_COUNT < CNT_MAX) ? SITE_COUNT : CNT_MAX;

  typedef enum logic [OP_W-1:0] {
    OP_INIT   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_READ   = 2'd2
  } opcode_t;

  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [SITE_W-1:0] site_t;
  typedef logic [NBR_W-1:0]  nbr_t;
  typedef logic [THR_W-1:0]  thr_t;

  // Threshold values after reset, indexed by the count of up neighbors.
  localparam thr_t THR_RESET [THR_COUNT] = '{
    32'd0, 32'd0, 32'd0, 32'd1073741823, 32'd2147483647, 32'd2147483647,
    32'd2147483647
  };

  // Fold an out-of-range column into the lattice.
  function automatic col_t col_wrap(input col_t c);
    return col_t'(int'(c) % LATTICE_WIDTH);
  endfunction

  // Fold an out-of-range row into the lattice.
  function automatic row_t row_wrap(input row_t r);
    return row_t'(int'(r) % LATTICE_HEIGHT);
  endfunction

  // Flat site index of an in-range column and row.
  function automatic site_t site_index(input col_t c, input row_t r);
    return site_t'(int'(r) * LATTICE_WIDTH + int'(c));
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ihb_neighbors.sv
// Counts the up spins among the six triangular-lattice neighbors of a site,
// with periodic wraparound. Depends on ihb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ihb_neighbors
  import ihb_pkg::*;
(
  input  wire logic [SITE_COUNT-1:0] spins,
  input  wire col_t                  col,
  input  wire row_t                  row,
  output      nbr_t                  up_neighbors
);

  col_t xp;
  col_t xm;
  row_t yp;
  row_t ym;
  logic [5:0] nbr_bits;

  // Wrapped coordinates of the adjacent columns and rows.
  always_comb begin
    xp = (int'(col) == LATTICE_WIDTH - 1)  ? '0 : col + col_t'(1);
    xm = (col == '0) ? col_t'(LATTICE_WIDTH - 1) : col - col_t'(1);
    yp = (int'(row) == LATTICE_HEIGHT - 1) ? '0 : row + row_t'(1);
    ym = (row == '0) ? row_t'(LATTICE_HEIGHT - 1) : row - row_t'(1);
  end

  // The six neighbors, including the two diagonals along (+1,+1) and (-1,-1).
  always_comb begin
    nbr_bits[0] = spins[site_index(col, yp)];
    nbr_bits[1] = spins[site_index(xp, row)];
    nbr_bits[2] = spins[site_index(xp, yp)];
    nbr_bits[3] = spins[site_index(col, ym)];
    nbr_bits[4] = spins[site_index(xm, row)];
    nbr_bits[5] = spins[site_index(xm, ym)];
  end

  // Population count of the neighbor spins; this selects the threshold.
  always_comb begin
    up_neighbors = '0;
    for (int i = 0; i < 6; i++) begin
      up_neighbors = up_neighbors + nbr_t'(nbr_bits[i]);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ising_heat_bath_site_update.sv
// Heat-bath site update for a periodic 4 x 8 triangular Ising lattice held in
// flip-flops. A command is taken at every clock edge with start high and busy
// low; busy is high only right after reset. Every command yields exactly one
// result word, shown for one cycle with done high. Each command is registered
// first; in the following cycle the result registers are loaded and the spin
// written: an update compares the draw with the threshold selected by the six
// neighbors, an init takes the spin from bit 0 of the draw, and a read keeps
// the spin and clears the up counter. One command per cycle is sustained, and
// each command sees the lattice as left by the one before it. The receiver
// cannot stall results. Thresholds are written
// through the cfg port, which is always ready; write them only while no
// command is in flight.
// Depends on ihb_pkg and ihb_neighbors.
`timescale 1ns / 1ps
`default_nettype none

module ising_heat_bath_site_update
  import ihb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Command word
  input  wire logic                 start,
  output      logic                 busy,
  input  wire logic [OP_W-1:0]      opcode,
  input  wire logic [COL_W-1:0]     site_col,
  input  wire logic [ROW_W-1:0]     site_row,
  input  wire logic [DRAW_W-1:0]    random_draw,
  // Result word
  output      logic                 done,
  output      logic                 new_spin_up,
  output      logic signed [MAG_W-1:0] magnetization_sum,
  output      logic [CNT_W-1:0]     up_count,
  // Threshold write port
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [THR_W-1:0]     cfg_data
);

  // Registered command
  logic                s1_valid;
  opcode_t             s1_op;
  col_t                s1_col;
  row_t                s1_row;
  logic [DRAW_W-1:0]   s1_draw;

  // Block state
  logic [SITE_COUNT-1:0]   spin_store;
  logic [SITE_COUNT-1:0]   spin_store_next;
  logic signed [MAG_W-1:0] spin_sum;
  logic signed [MAG_W-1:0] spin_sum_next;
  logic [CNT_W-1:0]        up_counter;
  logic [CNT_W-1:0]        up_counter_next;
  thr_t                    thr [THR_COUNT];

  // Update datapath
  site_t            idx;
  nbr_t             up_neighbors;
  logic             spin_cur;
  logic             spin_new;
  logic [CNT_W-1:0] count_after;

  logic accept;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Command register; busy is high only in reset and right after it.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      s1_valid <= 1'b0;
    end else begin
      busy     <= 1'b0;
      s1_valid <= accept;
    end
    if (accept) begin
      s1_op   <= opcode_t'(opcode);
      s1_col  <= col_wrap(site_col);
      s1_row  <= row_wrap(site_row);
      s1_draw <= random_draw;
    end
  end

  // Threshold registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < THR_COUNT; i++) begin
        thr[i] <= THR_RESET[i];
      end
    end else if (cfg_valid && cfg_ready && int'(cfg_index) < THR_COUNT) begin
      thr[cfg_index] <= cfg_data;
    end
  end

  ihb_neighbors u_neighbors (
    .spins        (spin_store),
    .col          (s1_col),
    .row          (s1_row),
    .up_neighbors (up_neighbors)
  );

  assign idx      = site_index(s1_col, s1_row);
  assign spin_cur = spin_store[idx];

  // New spin, counter and magnetization for the registered command.
  always_comb begin
    spin_new    = spin_cur;
    count_after = up_counter;
    case (s1_op)
      OP_INIT: begin
        spin_new = s1_draw[0];
      end
      OP_UPDATE: begin
        spin_new = ({1'b0, s1_draw} < thr[up_neighbors]);
        if (spin_new && int'(up_counter) < COUNT_LIMIT) begin
          count_after = up_counter + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase

    up_counter_next = (s1_op == OP_READ) ? '0 : count_after;

    spin_store_next      = spin_store;
    spin_store_next[idx] = spin_new;

    spin_sum_next = spin_sum;
    if (spin_new != spin_cur) begin
      spin_sum_next = spin_new ? spin_sum + MAG_W'(2) : spin_sum - MAG_W'(2);
    end
  end

  // Lattice state and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      spin_store <= '0;
      spin_sum   <= MAG_W'(-SITE_COUNT);
      up_counter <= '0;
      done       <= 1'b0;
    end else begin
      done <= s1_valid;
      if (s1_valid) begin
        spin_store <= spin_store_next;
        spin_sum   <= spin_sum_next;
        up_counter <= up_counter_next;
      end
    end
    if (s1_valid) begin
      new_spin_up       <= spin_new;
      magnetization_sum <= spin_sum_next;
      up_count          <= count_after;
    end
  end

`ifndef ASSERT_OFF
  // Every accepted command raises done, through the command and done registers.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("result strobe missing after accepted command");

  // The up counter never passes its saturation limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    int'(up_counter) <= COUNT_LIMIT)
    else $error("up counter beyond its limit");

  // The running magnetization matches the stored spins.
  a_mag_consistent: assert property (@(posedge clk) disable iff (rst)
    int'(spin_sum) == 2 * $countones(spin_store) - SITE_COUNT)
    else $error("magnetization out of step with spin store");

  // A read command leaves the counter cleared.
  a_read_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_op == OP_READ) |=> (up_counter == '0))
    else $error("counter not cleared by read");
`endif

endmodule

`default_nettype wire
